// ----- design/gsch_pkg.sv -----
package gsch_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_W = 16;
	// Hull runs need at least this many points, and the sort starts at this slot.
	localparam int MIN_HULL = 3;
	localparam int SORT_FIRST = 2;

	typedef struct packed {
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		point_t pt;
		logic   last;
	} qitem_t;

	typedef struct packed {
		logic start;
		logic full;
	} geom_req_t;

	typedef struct packed {
		logic done;
		logic result;
	} geom_rsp_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_SW0, ST_SW1, ST_SW2,
		ST_SO_KEY, ST_SO_KEYD, ST_SO_RD, ST_SO_RDD, ST_SO_GO, ST_SO_WT, ST_SO_PUT,
		ST_SC_I0, ST_SC_I1, ST_SC_I2, ST_SC_NEXT, ST_SC_PD, ST_SC_CHK, ST_SC_GO,
		ST_SC_WT, ST_SC_P1, ST_SC_P2, ST_SC_PUSH,
		ST_EM_SK, ST_EM_RD, ST_EM_OUT, ST_SM_RD
	} back_state_t;

	function automatic logic signed [COORD_W:0] diff17(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] ea;
		logic signed [COORD_W:0] eb;
		ea = {a[COORD_W-1], a};
		eb = {b[COORD_W-1], b};
		return ea - eb;
	endfunction

endpackage

// ----- design/gsch_in_if.sv -----
interface gsch_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] point_x;
	logic [15:0] point_y;
	logic        last_point;

	modport source(output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink(input valid, input point_x, input point_y, input last_point,
		output ready);
endinterface

// ----- design/gsch_out_if.sv -----
interface gsch_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] vertex_x;
	logic [15:0] vertex_y;
	logic        last_vertex;

	modport source(output valid, output vertex_x, output vertex_y, output last_vertex,
		input ready);
	modport sink(input valid, input vertex_x, input vertex_y, input last_vertex,
		output ready);
endinterface

// ----- design/gsch_front.sv -----
module gsch_front (
	input  logic            clk,
	input  logic            arst_n,
	gsch_in_if.sink         points,
	output logic            q_valid,
	output gsch_pkg::qitem_t q_item,
	input  logic            q_ready
);
	import gsch_pkg::*;

	qitem_t     ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	qitem_t     in_item;

	assign points.ready = (cnt_q != 2'd2);
	assign push = points.valid && points.ready;
	assign pop = q_valid && q_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = ent_q[rp_q];

	always_comb begin
		in_item.pt.x = points.point_x;
		in_item.pt.y = points.point_y;
		in_item.last = points.last_point;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ----- design/gsch_geom.sv -----
module gsch_geom (
	input  logic               clk,
	input  logic               arst_n,
	input  gsch_pkg::point_t   a,
	input  gsch_pkg::point_t   b,
	input  gsch_pkg::point_t   c,
	input  gsch_pkg::geom_req_t req,
	output gsch_pkg::geom_rsp_t rsp
);
	import gsch_pkg::*;

	// One shared multiplier walks the products in turn: two for the turn,
	// then four squares for the two distances in a full ordering compare.
	logic               busy_q;
	logic               done_q;
	logic               full_q;
	logic [2:0]         step_q;
	logic signed [16:0] m_a;
	logic signed [16:0] m_b;
	logic signed [33:0] prod;
	logic signed [34:0] prod_x;
	logic signed [34:0] acc_t_q;
	logic signed [34:0] acc_p_q;
	logic signed [34:0] acc_q_q;

	always_comb begin
		case (step_q)
			3'd0: begin
				m_a = diff17(b.y, a.y);
				m_b = diff17(c.x, b.x);
			end
			3'd1: begin
				m_a = diff17(b.x, a.x);
				m_b = diff17(c.y, b.y);
			end
			3'd2: begin
				m_a = diff17(b.x, a.x);
				m_b = m_a;
			end
			3'd3: begin
				m_a = diff17(b.y, a.y);
				m_b = m_a;
			end
			3'd4: begin
				m_a = diff17(c.x, a.x);
				m_b = m_a;
			end
			default: begin
				m_a = diff17(c.y, a.y);
				m_b = m_a;
			end
		endcase
		prod = 34'(m_a) * 34'(m_b);
		prod_x = {prod[33], prod};
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			case (step_q)
				3'd0: acc_t_q <= prod_x;
				3'd1: acc_t_q <= acc_t_q - prod_x;
				3'd2: acc_p_q <= prod_x;
				3'd3: acc_p_q <= acc_p_q + prod_x;
				3'd4: acc_q_q <= prod_x;
				default: acc_q_q <= acc_q_q + prod_x;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			full_q <= 1'b0;
			step_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					busy_q <= 1'b1;
					full_q <= req.full;
					step_q <= 3'd0;
				end
			end else if ((step_q == 3'd1 && !full_q) || step_q == 3'd5) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (full_q && acc_t_q == 35'sd0) begin
			rsp.result = (acc_p_q < acc_q_q);
		end else begin
			rsp.result = (acc_t_q < 35'sd0);
		end
	end
endmodule

// ----- design/gsch_back.sv -----
module gsch_back #(
	parameter int MAX_POINTS = gsch_pkg::MAX_POINTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  gsch_pkg::qitem_t    q_item,
	output logic                q_ready,
	output gsch_pkg::point_t    g_a,
	output gsch_pkg::point_t    g_b,
	output gsch_pkg::point_t    g_c,
	output gsch_pkg::geom_req_t g_req,
	input  gsch_pkg::geom_rsp_t g_rsp,
	gsch_out_if.source          vertices
);
	import gsch_pkg::*;

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] C_MAX = CW'(MAX_POINTS);
	localparam logic [CW-1:0] C_ONE = CW'(1);
	localparam logic [CW-1:0] C_TWO = CW'(SORT_FIRST);
	localparam logic [CW-1:0] C_THREE = CW'(MIN_HULL);

	point_t       store_mem [MAX_POINTS];
	logic [IW-1:0] stack_mem [MAX_POINTS];

	back_state_t  state_q, state_d;

	logic [CW-1:0] cnt_q, n_q, i_q, j_q, top_q, e_q, lim_q;
	logic [IW-1:0] best_q;
	point_t        bestpt_q, key_q, sp_q, tp_q, pi_q;
	point_t        ga_q, gb_q, gc_q;
	point_t        rd_q;
	logic [IW-1:0] sk_rd_q;
	logic          small_q;
	logic          out_valid_q;
	point_t        out_pt_q;
	logic          out_last_q;

	logic          we, rd_en, sk_we, sk_rd_en;
	logic [IW-1:0] waddr, raddr, sk_waddr, sk_raddr, sk_wdata;
	point_t        wdata;
	logic          in_fire, out_free, better, stored;
	logic [CW-1:0] n_new;

	assign in_fire = q_valid && q_ready;
	assign out_free = !out_valid_q || vertices.ready;
	assign stored = (cnt_q < C_MAX);
	assign n_new = stored ? cnt_q + C_ONE : cnt_q;
	assign better = (cnt_q == '0) || ($signed(q_item.pt.y) < $signed(bestpt_q.y)) ||
		(($signed(q_item.pt.y) == $signed(bestpt_q.y)) &&
		($signed(q_item.pt.x) >= $signed(bestpt_q.x)));

	assign g_a = ga_q;
	assign g_b = gb_q;
	assign g_c = gc_q;

	assign vertices.valid = out_valid_q;
	assign vertices.vertex_x = out_pt_q.x;
	assign vertices.vertex_y = out_pt_q.y;
	assign vertices.last_vertex = out_last_q;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = '0;
		wdata = key_q;
		rd_en = 1'b0;
		raddr = '0;
		sk_we = 1'b0;
		sk_waddr = '0;
		sk_wdata = '0;
		sk_rd_en = 1'b0;
		sk_raddr = '0;
		g_req.start = 1'b0;
		g_req.full = 1'b0;
		q_ready = 1'b0;
		case (state_q)
			ST_LOAD: begin
				q_ready = 1'b1;
				if (in_fire) begin
					we = stored;
					waddr = cnt_q[IW-1:0];
					wdata = q_item.pt;
					if (q_item.last) begin
						if (n_new == '0) begin
							state_d = ST_LOAD;
						end else if (n_new < C_THREE) begin
							state_d = ST_SM_RD;
						end else begin
							state_d = ST_SW0;
						end
					end
				end
			end
			ST_SW0: begin
				rd_en = 1'b1;
				raddr = '0;
				state_d = ST_SW1;
			end
			ST_SW1: begin
				we = 1'b1;
				waddr = best_q;
				wdata = rd_q;
				state_d = ST_SW2;
			end
			ST_SW2: begin
				we = 1'b1;
				waddr = '0;
				wdata = bestpt_q;
				state_d = ST_SO_KEY;
			end
			ST_SO_KEY: begin
				rd_en = 1'b1;
				raddr = i_q[IW-1:0];
				state_d = ST_SO_KEYD;
			end
			ST_SO_KEYD: state_d = ST_SO_RD;
			ST_SO_RD: begin
				if (j_q > C_ONE) begin
					rd_en = 1'b1;
					raddr = IW'(j_q - C_ONE);
					state_d = ST_SO_RDD;
				end else begin
					state_d = ST_SO_PUT;
				end
			end
			ST_SO_RDD: state_d = ST_SO_GO;
			ST_SO_GO: begin
				g_req.start = 1'b1;
				g_req.full = 1'b1;
				state_d = ST_SO_WT;
			end
			ST_SO_WT: begin
				if (g_rsp.done) begin
					if (g_rsp.result) begin
						we = 1'b1;
						waddr = j_q[IW-1:0];
						wdata = gc_q;
						state_d = ST_SO_RD;
					end else begin
						state_d = ST_SO_PUT;
					end
				end
			end
			ST_SO_PUT: begin
				we = 1'b1;
				waddr = j_q[IW-1:0];
				wdata = key_q;
				state_d = (i_q + C_ONE == n_q) ? ST_SC_I0 : ST_SO_KEY;
			end
			ST_SC_I0: begin
				sk_we = 1'b1;
				sk_waddr = '0;
				sk_wdata = '0;
				rd_en = 1'b1;
				raddr = IW'(1);
				state_d = ST_SC_I1;
			end
			ST_SC_I1: begin
				sk_we = 1'b1;
				sk_waddr = IW'(1);
				sk_wdata = IW'(1);
				rd_en = 1'b1;
				raddr = IW'(SORT_FIRST);
				state_d = ST_SC_I2;
			end
			ST_SC_I2: begin
				sk_we = 1'b1;
				sk_waddr = IW'(SORT_FIRST);
				sk_wdata = IW'(SORT_FIRST);
				state_d = ST_SC_NEXT;
			end
			ST_SC_NEXT: begin
				if (i_q == n_q) begin
					state_d = ST_EM_SK;
				end else begin
					rd_en = 1'b1;
					raddr = i_q[IW-1:0];
					state_d = ST_SC_PD;
				end
			end
			ST_SC_PD: state_d = ST_SC_CHK;
			ST_SC_CHK: state_d = (top_q > C_ONE) ? ST_SC_GO : ST_SC_PUSH;
			ST_SC_GO: begin
				g_req.start = 1'b1;
				state_d = ST_SC_WT;
			end
			ST_SC_WT: begin
				if (g_rsp.done) begin
					if (g_rsp.result) begin
						state_d = ST_SC_PUSH;
					end else if (top_q > C_TWO) begin
						// The entry below the new top one becomes the new second.
						sk_rd_en = 1'b1;
						sk_raddr = IW'(top_q - C_THREE);
						state_d = ST_SC_P1;
					end else begin
						state_d = ST_SC_PUSH;
					end
				end
			end
			ST_SC_P1: begin
				rd_en = 1'b1;
				raddr = sk_rd_q;
				state_d = ST_SC_P2;
			end
			ST_SC_P2: state_d = ST_SC_CHK;
			ST_SC_PUSH: begin
				if (top_q < C_MAX) begin
					sk_we = 1'b1;
					sk_waddr = top_q[IW-1:0];
					sk_wdata = i_q[IW-1:0];
				end
				state_d = ST_SC_NEXT;
			end
			ST_EM_SK: begin
				sk_rd_en = 1'b1;
				sk_raddr = e_q[IW-1:0];
				state_d = ST_EM_RD;
			end
			ST_EM_RD: begin
				rd_en = 1'b1;
				raddr = sk_rd_q;
				state_d = ST_EM_OUT;
			end
			ST_SM_RD: begin
				rd_en = 1'b1;
				raddr = e_q[IW-1:0];
				state_d = ST_EM_OUT;
			end
			ST_EM_OUT: begin
				if (out_free) begin
					if (e_q + C_ONE == lim_q) begin
						state_d = ST_LOAD;
					end else begin
						state_d = small_q ? ST_SM_RD : ST_EM_SK;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= store_mem[raddr];
		end
		if (sk_we) begin
			stack_mem[sk_waddr] <= sk_wdata;
		end
		if (sk_rd_en) begin
			sk_rd_q <= stack_mem[sk_raddr];
		end
	end

	// Datapath registers that follow the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (in_fire && stored && better) begin
					best_q <= cnt_q[IW-1:0];
					bestpt_q <= q_item.pt;
				end
				if (in_fire && q_item.last) begin
					n_q <= n_new;
					e_q <= '0;
					lim_q <= n_new;
					small_q <= 1'b1;
					i_q <= C_TWO;
				end
			end
			ST_SO_KEYD: begin
				key_q <= rd_q;
				j_q <= i_q;
			end
			ST_SO_RDD: begin
				ga_q <= bestpt_q;
				gb_q <= key_q;
				gc_q <= rd_q;
			end
			ST_SO_WT: begin
				if (g_rsp.done && g_rsp.result) begin
					j_q <= j_q - C_ONE;
				end
			end
			ST_SO_PUT: begin
				i_q <= i_q + C_ONE;
			end
			ST_SC_I1: sp_q <= rd_q;
			ST_SC_I2: begin
				tp_q <= rd_q;
				top_q <= C_THREE;
				i_q <= C_THREE;
			end
			ST_SC_NEXT: begin
				if (i_q == n_q) begin
					e_q <= '0;
					lim_q <= top_q;
					small_q <= 1'b0;
				end
			end
			ST_SC_PD: pi_q <= rd_q;
			ST_SC_CHK: begin
				ga_q <= sp_q;
				gb_q <= tp_q;
				gc_q <= pi_q;
			end
			ST_SC_WT: begin
				if (g_rsp.done && !g_rsp.result) begin
					top_q <= top_q - C_ONE;
					tp_q <= sp_q;
				end
			end
			ST_SC_P2: sp_q <= rd_q;
			ST_SC_PUSH: begin
				if (top_q < C_MAX) begin
					top_q <= top_q + C_ONE;
					sp_q <= tp_q;
					tp_q <= pi_q;
				end
				i_q <= i_q + C_ONE;
			end
			ST_EM_OUT: begin
				if (out_free) begin
					e_q <= e_q + C_ONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EM_OUT && out_free) begin
			out_pt_q <= rd_q;
			out_last_q <= (e_q + C_ONE == lim_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				cnt_q <= q_item.last ? '0 : n_new;
			end
			if (state_q == ST_EM_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (vertices.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ----- design/graham_scan_convex_hull_unit.sv -----
// Points are taken one per cycle while the unit is loading (not sorting, scanning or
// emitting), through a two-beat intake queue into the point memory. After the last point:
// anchor swap, insertion sort by compares, scan by turn tests (a pop reloads the second
// stack entry), then the hull vertices out of the memories.
// Runs of fewer than three points give each point back as it came in.
// The asynchronous reset empties the point set, the queue and the output register;
// the memories are not cleared and need no clearing pass.
module graham_scan_convex_hull_unit #(
	parameter int MAX_POINTS = gsch_pkg::MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gsch_in_if.sink     points,
	gsch_out_if.source  vertices
);
	import gsch_pkg::*;

	logic      q_valid;
	qitem_t    q_item;
	logic      q_ready;
	point_t    g_a, g_b, g_c;
	geom_req_t g_req;
	geom_rsp_t g_rsp;

	gsch_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.points  (points),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_ready (q_ready)
	);

	gsch_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.a      (g_a),
		.b      (g_b),
		.c      (g_c),
		.req    (g_req),
		.rsp    (g_rsp)
	);

	gsch_back #(
		.MAX_POINTS (MAX_POINTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_ready  (q_ready),
		.g_a      (g_a),
		.g_b      (g_b),
		.g_c      (g_c),
		.g_req    (g_req),
		.g_rsp    (g_rsp),
		.vertices (vertices)
	);
endmodule
